@@ sv/wwdt_pkg.sv @@
// Shared types, request codes and constants of the windowed watchdog timer
package wwdt_pkg;

  // Request codes
  localparam logic [3:0] REQ_INIT     = 4'd0;
  localparam logic [3:0] REQ_DEINIT   = 4'd1;
  localparam logic [3:0] REQ_SET_MODE = 4'd2;
  localparam logic [3:0] REQ_KICK     = 4'd3;
  localparam logic [3:0] REQ_FORCE    = 4'd4;
  localparam logic [3:0] REQ_ADVANCE  = 4'd5;
  localparam logic [3:0] REQ_CLEAR    = 4'd6;
  localparam logic [3:0] REQ_SIM_TO   = 4'd7;
  localparam logic [3:0] REQ_SIM_WIN  = 4'd8;
  localparam logic [3:0] REQ_QUERY    = 4'd9;

  // Mode codes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_SLOW = 2'd1;
  localparam logic [1:0] MODE_FAST = 2'd2;

  // Status codes
  localparam logic [1:0] ST_UNINIT = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_BUSY   = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEFAULT_TO = 2'd0;
  localparam logic [1:0] CFG_SLOW_TO    = 2'd1;
  localparam logic [1:0] CFG_FAST_TO    = 2'd2;

  // Configuration reset values
  localparam logic [31:0] DEFAULT_TO_RST = 32'd1000;
  localparam logic [31:0] SLOW_TO_RST    = 32'd500;
  localparam logic [31:0] FAST_TO_RST    = 32'd50;

  // Flag bit positions
  localparam int FL_TIMEOUT = 0;
  localparam int FL_RESET   = 1;
  localparam int FL_WINDOW  = 2;
  localparam int FL_KICKED  = 3;

  // State of one watchdog instance
  typedef struct packed {
    logic        enabled;
    logic        running;
    logic [1:0]  cur_mode;
    logic [3:0]  flag_bits;
    logic [31:0] limit;
    logic [31:0] win_start;
    logic [31:0] win_end;
    logic [31:0] count;
    logic [31:0] elapsed;
    logic [31:0] kicks;
    logic [31:0] misses;
    logic [31:0] last_kick;
  } unit_t;

  // One result item
  typedef struct packed {
    logic        ok;
    logic [1:0]  status;
    logic        timeout_flag;
    logic        reset_flag;
    logic [31:0] kick_count;
    logic [31:0] miss_count;
    logic [31:0] count_now;
    logic [31:0] last_kick_time;
  } res_t;

  // Saturating 32-bit add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ sv/wwdt_bank.sv @@
// Register bank holding every watchdog instance and the global ready bit
module wwdt_bank #(
  parameter int INSTANCES = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          sel_idx,
  input  wwdt_pkg::unit_t     unit_nxt,
  input  logic                ready_nxt,
  output wwdt_pkg::unit_t     unit_rd,
  output logic                ready,
  output logic                others_idle
);

  wwdt_pkg::unit_t units_r [INSTANCES];
  logic            ready_r;

  // Select the addressed instance
  always_comb begin
    unit_rd = '0;
    for (int i = 0; i < INSTANCES; i++) begin
      if (sel_idx == 3'(i)) begin
        unit_rd = units_r[i];
      end
    end
  end

  // Check that every other instance is disabled with no flags raised
  always_comb begin
    others_idle = 1'b1;
    for (int i = 0; i < INSTANCES; i++) begin
      if (sel_idx != 3'(i) && (units_r[i].enabled || units_r[i].flag_bits != 4'd0)) begin
        others_idle = 1'b0;
      end
    end
  end

  // Write back the updated instance and ready bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < INSTANCES; i++) begin
        units_r[i] <= '0;
      end
      ready_r <= 1'b0;
    end else if (wr_en) begin
      for (int i = 0; i < INSTANCES; i++) begin
        if (sel_idx == 3'(i)) begin
          units_r[i] <= unit_nxt;
        end
      end
      ready_r <= ready_nxt;
    end
  end

  assign ready = ready_r;

endmodule

@@ sv/wwdt_eval.sv @@
// Single-pass evaluation of one request against one instance
module wwdt_eval (
  input  logic             in_range,
  input  logic [3:0]       req_type,
  input  logic [1:0]       mode,
  input  logic [31:0]      amount,
  input  logic [31:0]      init_timeout,
  input  logic [31:0]      default_to,
  input  logic [31:0]      slow_to,
  input  logic [31:0]      fast_to,
  input  wwdt_pkg::unit_t  unit_cur,
  input  logic             ready_cur,
  input  logic             others_idle,
  output wwdt_pkg::unit_t  unit_nxt,
  output logic             ready_nxt,
  output wwdt_pkg::res_t   res
);

  logic        ok;
  logic [31:0] adv_count;

  assign adv_count = wwdt_pkg::sat_add(unit_cur.count, amount);

  // Work out the new instance state
  always_comb begin
    unit_nxt  = unit_cur;
    ready_nxt = ready_cur;
    ok        = 1'b1;
    case (req_type)
      wwdt_pkg::REQ_INIT: begin
        unit_nxt          = '0;
        unit_nxt.limit    = (init_timeout != 32'd0) ? init_timeout : default_to;
        unit_nxt.enabled  = 1'b1;
        unit_nxt.running  = 1'b1;
        unit_nxt.cur_mode = wwdt_pkg::MODE_SLOW;
        ready_nxt         = 1'b1;
      end
      wwdt_pkg::REQ_DEINIT: begin
        unit_nxt = '0;
        if (others_idle) begin
          ready_nxt = 1'b0;
        end
      end
      wwdt_pkg::REQ_SET_MODE: begin
        case (mode)
          wwdt_pkg::MODE_OFF: begin
            unit_nxt.enabled  = 1'b0;
            unit_nxt.running  = 1'b0;
            unit_nxt.cur_mode = wwdt_pkg::MODE_OFF;
          end
          wwdt_pkg::MODE_SLOW: begin
            unit_nxt.enabled  = 1'b1;
            unit_nxt.running  = 1'b1;
            unit_nxt.cur_mode = wwdt_pkg::MODE_SLOW;
            unit_nxt.limit    = slow_to;
            unit_nxt.win_end  = slow_to;
            unit_nxt.count    = 32'd0;
          end
          wwdt_pkg::MODE_FAST: begin
            unit_nxt.enabled  = 1'b1;
            unit_nxt.running  = 1'b1;
            unit_nxt.cur_mode = wwdt_pkg::MODE_FAST;
            unit_nxt.limit    = fast_to;
            unit_nxt.win_end  = fast_to;
            unit_nxt.count    = 32'd0;
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      wwdt_pkg::REQ_KICK: begin
        if (unit_cur.enabled) begin
          if (unit_cur.count >= unit_cur.limit) begin
            unit_nxt.flag_bits[wwdt_pkg::FL_TIMEOUT] = 1'b1;
            unit_nxt.misses = wwdt_pkg::sat_add(unit_cur.misses, 32'd1);
            ok = 1'b0;
          end else if (unit_cur.flag_bits[wwdt_pkg::FL_WINDOW] &&
                       (unit_cur.count < unit_cur.win_start ||
                        unit_cur.count > unit_cur.win_end)) begin
            ok = 1'b0;
          end else begin
            unit_nxt.count = 32'd0;
            unit_nxt.kicks = wwdt_pkg::sat_add(unit_cur.kicks, 32'd1);
            unit_nxt.flag_bits[wwdt_pkg::FL_KICKED] = 1'b1;
            unit_nxt.last_kick = unit_cur.elapsed;
          end
        end
      end
      wwdt_pkg::REQ_FORCE: begin
        unit_nxt.flag_bits[wwdt_pkg::FL_TIMEOUT] = 1'b1;
        unit_nxt.flag_bits[wwdt_pkg::FL_RESET]   = 1'b1;
      end
      wwdt_pkg::REQ_ADVANCE: begin
        if (unit_cur.running) begin
          unit_nxt.elapsed = wwdt_pkg::sat_add(unit_cur.elapsed, amount);
          unit_nxt.count   = adv_count;
          if (adv_count >= unit_cur.limit) begin
            unit_nxt.flag_bits[wwdt_pkg::FL_TIMEOUT] = 1'b1;
          end
        end
      end
      wwdt_pkg::REQ_CLEAR: begin
        unit_nxt = '0;
      end
      wwdt_pkg::REQ_SIM_TO: begin
        unit_nxt.flag_bits[wwdt_pkg::FL_TIMEOUT] = 1'b1;
        unit_nxt.count = wwdt_pkg::sat_add(unit_cur.limit, 32'd1);
      end
      wwdt_pkg::REQ_SIM_WIN: begin
        unit_nxt.flag_bits[wwdt_pkg::FL_WINDOW] = 1'b1;
        unit_nxt.count = wwdt_pkg::sat_add(unit_cur.win_end, 32'd1);
      end
      wwdt_pkg::REQ_QUERY: begin
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Build the result from the state after the request
  always_comb begin
    res = '0;
    if (!in_range) begin
      res.status = wwdt_pkg::ST_ERROR;
    end else begin
      res.ok = ok;
      if (!ready_nxt) begin
        res.status = wwdt_pkg::ST_UNINIT;
      end else if (unit_nxt.flag_bits[wwdt_pkg::FL_TIMEOUT]) begin
        res.status = wwdt_pkg::ST_ERROR;
      end else if (unit_nxt.enabled && unit_nxt.running) begin
        res.status = wwdt_pkg::ST_BUSY;
      end else begin
        res.status = wwdt_pkg::ST_IDLE;
      end
      res.timeout_flag   = unit_nxt.flag_bits[wwdt_pkg::FL_TIMEOUT];
      res.reset_flag     = unit_nxt.flag_bits[wwdt_pkg::FL_RESET];
      res.kick_count     = unit_nxt.kicks;
      res.miss_count     = unit_nxt.misses;
      res.count_now      = unit_nxt.count;
      res.last_kick_time = unit_nxt.last_kick;
    end
  end

endmodule

@@ sv/windowed_watchdog_timer.sv @@
// Windowed watchdog timer bank: request register, evaluation and result register
//
// A bank of INSTANCES watchdogs, each driven by requests addressed to it.
// Input channel: a request is taken at a rising edge with start high and busy
// low; busy stays low, so a request can be issued in every cycle. The request
// is registered, evaluated against the addressed instance in one pass, and
// the instance state and the result are written together at the next edge.
// out_valid is high for one cycle per request, after the request and result
// registers. Throughput: one request per cycle, set by the single evaluation
// stage; back-to-back requests to the same instance see each other's updates.
// Result channel: every field sits on the out_ ports for the single cycle in
// which out_valid is high; the receiver cannot hold results off.
// Configuration: cfg_we writes cfg_data into the timeout register selected by
// cfg_index (default, slow, fast); an unknown index is ignored. Write only
// while no request is in flight.
// Reset (rst_n low, synchronous) clears every instance, drops the ready bit,
// empties the request and result stages and restores the timeout registers.
module windowed_watchdog_timer #(
  parameter int INSTANCES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_req_type,
  input  logic [2:0]  in_instance_req,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_amount,
  input  logic [31:0] in_init_timeout,
  output logic        out_valid,
  output logic        out_ok,
  output logic [1:0]  out_status,
  output logic        out_timeout_flag,
  output logic        out_reset_flag,
  output logic [31:0] out_kick_count,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_count_now,
  output logic [31:0] out_last_kick_time,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic            req_valid_r;
  logic [3:0]      req_type_r;
  logic [2:0]      inst_r;
  logic [1:0]      mode_r;
  logic [31:0]     amount_r;
  logic [31:0]     init_to_r;
  logic [31:0]     default_to_r;
  logic [31:0]     slow_to_r;
  logic [31:0]     fast_to_r;
  logic            out_valid_r;
  wwdt_pkg::res_t  res_r;

  logic            in_range;
  logic            bank_wr;
  wwdt_pkg::unit_t unit_cur;
  wwdt_pkg::unit_t unit_nxt;
  logic            ready_cur;
  logic            ready_nxt;
  logic            others_idle;
  wwdt_pkg::res_t  res_nxt;

  assign busy = 1'b0;

  // Hold the timeout registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_to_r <= wwdt_pkg::DEFAULT_TO_RST;
      slow_to_r    <= wwdt_pkg::SLOW_TO_RST;
      fast_to_r    <= wwdt_pkg::FAST_TO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wwdt_pkg::CFG_DEFAULT_TO: default_to_r <= cfg_data;
        wwdt_pkg::CFG_SLOW_TO:    slow_to_r    <= cfg_data;
        wwdt_pkg::CFG_FAST_TO:    fast_to_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Register the request on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_type_r <= in_req_type;
      inst_r     <= in_instance_req;
      mode_r     <= in_mode;
      amount_r   <= in_amount;
      init_to_r  <= in_init_timeout;
    end
  end

  assign in_range = {1'b0, inst_r} < 4'(INSTANCES);
  assign bank_wr  = req_valid_r && in_range;

  wwdt_bank #(
    .INSTANCES (INSTANCES)
  ) u_bank (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (bank_wr),
    .sel_idx     (inst_r),
    .unit_nxt    (unit_nxt),
    .ready_nxt   (ready_nxt),
    .unit_rd     (unit_cur),
    .ready       (ready_cur),
    .others_idle (others_idle)
  );

  wwdt_eval u_eval (
    .in_range     (in_range),
    .req_type     (req_type_r),
    .mode         (mode_r),
    .amount       (amount_r),
    .init_timeout (init_to_r),
    .default_to   (default_to_r),
    .slow_to      (slow_to_r),
    .fast_to      (fast_to_r),
    .unit_cur     (unit_cur),
    .ready_cur    (ready_cur),
    .others_idle  (others_idle),
    .unit_nxt     (unit_nxt),
    .ready_nxt    (ready_nxt),
    .res          (res_nxt)
  );

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = res_r.ok;
  assign out_status         = res_r.status;
  assign out_timeout_flag   = res_r.timeout_flag;
  assign out_reset_flag     = res_r.reset_flag;
  assign out_kick_count     = res_r.kick_count;
  assign out_miss_count     = res_r.miss_count;
  assign out_count_now      = res_r.count_now;
  assign out_last_kick_time = res_r.last_kick_time;

  // Every result follows a matching earlier request transfer
  a_res_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching request transfer");

  // The forced-reset flag never stands without the timeout flag
  a_reset_implies_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reset_flag |-> out_timeout_flag)
    else $error("reset flag reported without timeout flag");

  // A busy instance never reports a timeout
  a_busy_no_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wwdt_pkg::ST_BUSY |-> !out_timeout_flag)
    else $error("busy status reported with timeout flag set");

  // A timeout flag shows either error or uninitialised status
  a_timeout_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timeout_flag |->
      out_status == wwdt_pkg::ST_ERROR || out_status == wwdt_pkg::ST_UNINIT)
    else $error("timeout flag reported with idle or busy status");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the windowed watchdog timer bank
module tb_top;

  localparam int NUM_UNITS = 3;
  localparam int IDX_W = $clog2(NUM_UNITS);
  localparam logic [3:0] REQ_UNKNOWN = 4'd15;
  localparam logic [1:0] MODE_BAD = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    bit        enabled;
    bit        running;
    bit [1:0]  cur_mode;
    bit [3:0]  flag_bits;
    bit [31:0] limit;
    bit [31:0] win_start;
    bit [31:0] win_end;
    bit [31:0] count;
    bit [31:0] elapsed;
    bit [31:0] kicks;
    bit [31:0] misses;
    bit [31:0] last_kick;
  } unit_state_t;

  typedef struct packed {
    bit        ok;
    bit [1:0]  status;
    bit        timeout_flag;
    bit        reset_flag;
    bit [31:0] kick_count;
    bit [31:0] miss_count;
    bit [31:0] count_now;
    bit [31:0] last_kick_time;
  } wd_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_req_type = '0;
  logic [2:0]  in_instance_req = '0;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_amount = '0;
  logic [31:0] in_init_timeout = '0;
  logic        out_valid;
  logic        out_ok;
  logic [1:0]  out_status;
  logic        out_timeout_flag;
  logic        out_reset_flag;
  logic [31:0] out_kick_count;
  logic [31:0] out_miss_count;
  logic [31:0] out_count_now;
  logic [31:0] out_last_kick_time;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Watchdog model state and timeout registers
  unit_state_t units [NUM_UNITS];
  bit          bank_ready;
  bit [31:0]   default_to;
  bit [31:0]   slow_to;
  bit [31:0]   fast_to;

  wd_result_t  results_due [$];
  int          errors = 0;

  windowed_watchdog_timer #(
    .INSTANCES(NUM_UNITS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_instance_req   (in_instance_req),
    .in_mode           (in_mode),
    .in_amount         (in_amount),
    .in_init_timeout   (in_init_timeout),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_status        (out_status),
    .out_timeout_flag  (out_timeout_flag),
    .out_reset_flag    (out_reset_flag),
    .out_kick_count    (out_kick_count),
    .out_miss_count    (out_miss_count),
    .out_count_now     (out_count_now),
    .out_last_kick_time(out_last_kick_time),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abandon a hung run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit [31:0] add_clamped(bit [31:0] a, bit [31:0] b);
    bit [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ALL_ONES : s[31:0];
  endfunction

  function automatic unit_state_t enter_mode(unit_state_t u, bit [1:0] m, bit [31:0] t);
    u.enabled  = 1'b1;
    u.running  = 1'b1;
    u.cur_mode = m;
    u.limit    = t;
    u.win_end  = t;
    u.count    = '0;
    return u;
  endfunction

  // Apply one request to the model and return the result it gives
  function automatic wd_result_t apply_request(bit [3:0] req, bit [2:0] inst, bit [1:0] md,
                                               bit [31:0] amt, bit [31:0] init_to);
    wd_result_t  r;
    unit_state_t u;
    bit          ok;
    bit          all_idle;
    r = '0;
    if (inst >= NUM_UNITS) begin
      r.status = wwdt_pkg::ST_ERROR;
      return r;
    end
    u = units[inst[IDX_W-1:0]];
    ok = 1'b1;
    case (req)
      wwdt_pkg::REQ_INIT: begin
        u = '0;
        u.limit = (init_to != 0) ? init_to : default_to;
        u.enabled = 1'b1;
        u.running = 1'b1;
        u.cur_mode = wwdt_pkg::MODE_SLOW;
        bank_ready = 1'b1;
      end
      wwdt_pkg::REQ_DEINIT: begin
        u = '0;
        units[inst[IDX_W-1:0]] = u;
        all_idle = 1'b1;
        for (int i = 0; i < NUM_UNITS; i++) begin
          if (units[i].enabled || units[i].flag_bits != 0) all_idle = 1'b0;
        end
        if (all_idle) bank_ready = 1'b0;
      end
      wwdt_pkg::REQ_SET_MODE: begin
        case (md)
          wwdt_pkg::MODE_OFF: begin
            u.enabled = 1'b0;
            u.running = 1'b0;
            u.cur_mode = wwdt_pkg::MODE_OFF;
          end
          wwdt_pkg::MODE_SLOW: u = enter_mode(u, wwdt_pkg::MODE_SLOW, slow_to);
          wwdt_pkg::MODE_FAST: u = enter_mode(u, wwdt_pkg::MODE_FAST, fast_to);
          default:   ok = 1'b0;
        endcase
      end
      wwdt_pkg::REQ_KICK: begin
        if (!u.enabled) begin
          ok = 1'b1;
        end else if (u.count >= u.limit) begin
          u.flag_bits[wwdt_pkg::FL_TIMEOUT] = 1'b1;
          u.misses = add_clamped(u.misses, 1);
          ok = 1'b0;
        end else if (u.flag_bits[wwdt_pkg::FL_WINDOW] &&
                     (u.count < u.win_start || u.count > u.win_end)) begin
          ok = 1'b0;
        end else begin
          u.count = '0;
          u.kicks = add_clamped(u.kicks, 1);
          u.flag_bits[wwdt_pkg::FL_KICKED] = 1'b1;
          u.last_kick = u.elapsed;
        end
      end
      wwdt_pkg::REQ_FORCE: begin
        u.flag_bits[wwdt_pkg::FL_TIMEOUT] = 1'b1;
        u.flag_bits[wwdt_pkg::FL_RESET] = 1'b1;
      end
      wwdt_pkg::REQ_ADVANCE: begin
        if (u.running) begin
          u.elapsed = add_clamped(u.elapsed, amt);
          u.count = add_clamped(u.count, amt);
          if (u.count >= u.limit) u.flag_bits[wwdt_pkg::FL_TIMEOUT] = 1'b1;
        end
      end
      wwdt_pkg::REQ_CLEAR: u = '0;
      wwdt_pkg::REQ_SIM_TO: begin
        u.flag_bits[wwdt_pkg::FL_TIMEOUT] = 1'b1;
        u.count = add_clamped(u.limit, 1);
      end
      wwdt_pkg::REQ_SIM_WIN: begin
        u.flag_bits[wwdt_pkg::FL_WINDOW] = 1'b1;
        u.count = add_clamped(u.win_end, 1);
      end
      wwdt_pkg::REQ_QUERY: ok = 1'b1;
      default:   ok = 1'b0;
    endcase
    units[inst[IDX_W-1:0]] = u;

    if (!bank_ready)                            r.status = wwdt_pkg::ST_UNINIT;
    else if (u.flag_bits[wwdt_pkg::FL_TIMEOUT]) r.status = wwdt_pkg::ST_ERROR;
    else if (u.enabled && u.running)            r.status = wwdt_pkg::ST_BUSY;
    else                                        r.status = wwdt_pkg::ST_IDLE;
    r.ok             = ok;
    r.timeout_flag   = u.flag_bits[wwdt_pkg::FL_TIMEOUT];
    r.reset_flag     = u.flag_bits[wwdt_pkg::FL_RESET];
    r.kick_count     = u.kicks;
    r.miss_count     = u.misses;
    r.count_now      = u.count;
    r.last_kick_time = u.last_kick;
    return r;
  endfunction

  function automatic void check_field(string name, bit [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    wd_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("ok", 32'(want.ok), 32'(out_ok));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("timeout_flag", 32'(want.timeout_flag), 32'(out_timeout_flag));
        check_field("reset_flag", 32'(want.reset_flag), 32'(out_reset_flag));
        check_field("kick_count", want.kick_count, out_kick_count);
        check_field("miss_count", want.miss_count, out_miss_count);
        check_field("count_now", want.count_now, out_count_now);
        check_field("last_kick_time", want.last_kick_time, out_last_kick_time);
      end
    end
  end

  // Present one request and hold it until the transfer
  task automatic send_request(input bit [3:0] req, input bit [2:0] inst, input bit [1:0] md,
                              input bit [31:0] amt, input bit [31:0] init_to);
    start           <= 1'b1;
    in_req_type     <= req;
    in_instance_req <= inst;
    in_mode         <= md;
    in_amount       <= amt;
    in_init_timeout <= init_to;
    @(posedge clk);
    while (busy === 1'b1) @(posedge clk);
    results_due.push_back(apply_request(req, inst, md, amt, init_to));
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result has come, then settle
  task automatic wait_for_results(input int settle);
    int guard;
    start <= 1'b0;
    guard = 0;
    @(negedge clk);
    while (results_due.size() != 0 && guard < 200) begin
      @(negedge clk);
      guard++;
    end
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      errors++;
      results_due.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] idx, input bit [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      wwdt_pkg::CFG_DEFAULT_TO: default_to = value;
      wwdt_pkg::CFG_SLOW_TO:    slow_to = value;
      wwdt_pkg::CFG_FAST_TO:    fast_to = value;
      default:        ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Access before any instance is initialised, bad addresses and bad codes
  task automatic test_uninitialised_access();
    send_request(wwdt_pkg::REQ_QUERY, 0, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_KICK, 1, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_ADVANCE, 2, wwdt_pkg::MODE_OFF, 123, 0);
    send_request(wwdt_pkg::REQ_QUERY, 3'd7, MODE_BAD, ALL_ONES, ALL_ONES);
    send_request(REQ_UNKNOWN, 0, wwdt_pkg::MODE_OFF, 0, 0);
    idle_sender(3);
  endtask

  // Default and explicit init, good and late kicks, time saturation
  task automatic test_kick_and_timeout();
    send_request(wwdt_pkg::REQ_INIT, 0, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_INIT, 1, wwdt_pkg::MODE_OFF, 0, ALL_ONES);
    send_request(wwdt_pkg::REQ_ADVANCE, 0, wwdt_pkg::MODE_OFF, 999, 0);
    send_request(wwdt_pkg::REQ_KICK, 0, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_ADVANCE, 0, wwdt_pkg::MODE_OFF, 1000, 0);
    send_request(wwdt_pkg::REQ_KICK, 0, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_FORCE, 2, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_SIM_TO, 1, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_ADVANCE, 1, wwdt_pkg::MODE_OFF, ALL_ONES, 0);
    send_request(wwdt_pkg::REQ_ADVANCE, 1, wwdt_pkg::MODE_OFF, ALL_ONES, 0);
    idle_sender(2);
  endtask

  // Mode changes, window violation and rejected mode
  task automatic test_modes_and_window();
    send_request(wwdt_pkg::REQ_SET_MODE, 2, wwdt_pkg::MODE_SLOW, 0, 0);
    send_request(wwdt_pkg::REQ_SIM_WIN, 2, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_KICK, 2, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_SET_MODE, 2, wwdt_pkg::MODE_FAST, 0, 0);
    send_request(wwdt_pkg::REQ_ADVANCE, 2, wwdt_pkg::MODE_OFF, 30, 0);
    send_request(wwdt_pkg::REQ_KICK, 2, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_SET_MODE, 0, MODE_BAD, 0, 0);
    send_request(wwdt_pkg::REQ_SET_MODE, 0, wwdt_pkg::MODE_OFF, 0, 0);
    idle_sender(1);
  endtask

  // Clear one instance, then deinit all so the bank drops its ready state
  task automatic test_teardown();
    send_request(wwdt_pkg::REQ_CLEAR, 0, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_DEINIT, 0, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_DEINIT, 1, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_DEINIT, 2, wwdt_pkg::MODE_OFF, 0, 0);
    send_request(wwdt_pkg::REQ_QUERY, 1, wwdt_pkg::MODE_OFF, 0, 0);
  endtask

  // Reprogram the timeouts while idle, then run random traffic in bursts
  task automatic test_random_settings(input bit [31:0] dflt, input bit [31:0] slow,
                                      input bit [31:0] fast, input int n_items);
    int        burst_left;
    int        pick;
    bit [3:0]  req;
    bit [2:0]  inst;
    bit [1:0]  md;
    bit [31:0] amt;
    bit [31:0] init_to;
    bit [31:0] lim;
    wait_for_results(3);
    write_config(CFG_UNUSED, $urandom);
    write_config(wwdt_pkg::CFG_DEFAULT_TO, dflt);
    write_config(wwdt_pkg::CFG_SLOW_TO, slow);
    write_config(wwdt_pkg::CFG_FAST_TO, fast);
    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)       req = wwdt_pkg::REQ_INIT;
      else if (pick < 9)  req = wwdt_pkg::REQ_DEINIT;
      else if (pick < 18) req = wwdt_pkg::REQ_SET_MODE;
      else if (pick < 45) req = wwdt_pkg::REQ_KICK;
      else if (pick < 50) req = wwdt_pkg::REQ_FORCE;
      else if (pick < 75) req = wwdt_pkg::REQ_ADVANCE;
      else if (pick < 79) req = wwdt_pkg::REQ_CLEAR;
      else if (pick < 83) req = wwdt_pkg::REQ_SIM_TO;
      else if (pick < 88) req = wwdt_pkg::REQ_SIM_WIN;
      else if (pick < 96) req = wwdt_pkg::REQ_QUERY;
      else                req = 4'($urandom_range(wwdt_pkg::REQ_QUERY + 1, REQ_UNKNOWN));

      inst = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NUM_UNITS, 7))
                                          : 3'($urandom_range(0, NUM_UNITS - 1));
      md = 2'($urandom_range(0, 3));
      lim = (inst < NUM_UNITS) ? units[inst[IDX_W-1:0]].limit : 32'd100;

      // Mostly steps that stay inside the window, so kicks get through
      case ($urandom_range(0, 9))
        0:       amt = $urandom;
        1:       amt = ALL_ONES;
        2:       amt = '0;
        8:       amt = $urandom_range(lim / 3, lim);
        default: amt = $urandom_range(0, lim / 3);
      endcase
      case ($urandom_range(0, 4))
        0, 1:    init_to = '0;
        2:       init_to = $urandom_range(1, 200);
        3:       init_to = $urandom;
        default: init_to = ALL_ONES;
      endcase

      send_request(req, inst, md, amt, init_to);

      // Gaps between bursts; now and then let everything drain
      burst_left--;
      if (burst_left <= 0) begin
        if ($urandom_range(0, 24) == 0) wait_for_results(1);
        else if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
        burst_left = $urandom_range(1, 30);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_UNITS; i++) units[i] = '0;
    bank_ready = 1'b0;
    default_to = wwdt_pkg::DEFAULT_TO_RST;
    slow_to    = wwdt_pkg::SLOW_TO_RST;
    fast_to    = wwdt_pkg::FAST_TO_RST;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_uninitialised_access();
    test_kick_and_timeout();
    test_modes_and_window();
    test_teardown();

    test_random_settings(wwdt_pkg::DEFAULT_TO_RST, wwdt_pkg::SLOW_TO_RST,
                         wwdt_pkg::FAST_TO_RST, 175);
    test_random_settings(32'd1, 32'd1, 32'd1, 175);
    test_random_settings(ALL_ONES, ALL_ONES, ALL_ONES, 175);
    test_random_settings(32'd0, 32'd0, 32'd0, 175);
    test_random_settings($urandom_range(10, 300), $urandom_range(10, 300),
                         $urandom_range(5, 100), 175);
    test_random_settings($urandom, $urandom, $urandom, 175);

    wait_for_results(5);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ windowed_watchdog_timer.f @@
sv/wwdt_pkg.sv
sv/wwdt_bank.sv
sv/wwdt_eval.sv
sv/windowed_watchdog_timer.sv
test/tb_top.sv
